>>> rtl/sars_pkg.sv
`timescale 1ns / 1ps

package sars_pkg;

  // Fixed field widths of the block's ports.
  localparam int unsigned SUM_W      = 30;
  localparam int unsigned VAL_W      = 18;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  // One in signed Q.16.
  localparam logic [SUM_W-1:0] UNIT_Q16 = SUM_W'(65536);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_WIDTH  = 2'd0,
    CFG_KERNEL_HEIGHT = 2'd1,
    CFG_CLAMP_TO_UNIT = 2'd2
  } cfg_idx_e;

endpackage

>>> rtl/summed_area_region_sum_core.sv
`timescale 1ns / 1ps
// Summed-area table with rectangle-sum queries.
// Input channel (push/full): kind_i selects a kernel entry load (entry_value_i, row-major)
// or a rectangle query (corner_x_i, corner_y_i, rect_width_i, rect_height_i).
// Result channel (empty/pop): one region_sum_o per query, none per load, in order.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 kernel width, 1 kernel height,
// 2 clamp-to-unit mode. Writing width or height restarts loading at the top left.
// The front stage takes one transaction per cycle while full is low, clamps the rectangle
// and forms the table row offsets, then hands it through a two-entry queue to the back end.
// The back end owns a single-port table memory: a load reads the entry above, then writes
// the new prefix sum; a query makes four reads, then forms the sum. The back end takes
// the next item from the queue only once it is done with the last one.
// The finished result waits in an output register; while pop is low the back end keeps
// working on loads until a query finishes; full rises when queue and front stage fill.
// Reset clears the load position and sets the kernel to 1 x 1 with clamping off; the
// table itself is not cleared, so a query must only cover entries loaded since reset.
module summed_area_region_sum_core
  import sars_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Item queue.
  input  logic                      push,
  output logic                      full,
  input  logic                      kind_i,
  input  logic signed [VAL_W-1:0]   entry_value_i,
  input  logic signed [COORD_W-1:0] corner_x_i,
  input  logic signed [COORD_W-1:0] corner_y_i,
  input  logic [LEN_W-1:0]          rect_width_i,
  input  logic [LEN_W-1:0]          rect_height_i,
  // Result queue.
  output logic                      empty,
  input  logic                      pop,
  output logic signed [SUM_W-1:0]   region_sum_o,
  // Configuration writes.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Work item passed from the front stage to the back end.
  typedef struct packed {
    kind_e                   kind;
    logic signed [VAL_W-1:0] value;
    logic [AW-1:0]           pos;
    logic [AW-1:0]           above;
    logic                    col0;
    logic                    row_nz;
    logic                    nonempty;
    logic                    xs_nz;
    logic                    ys_nz;
    logic [AW-1:0]           off_bot;
    logic [AW-1:0]           off_top;
    logic [SIDE_W-1:0]       col_r;
    logic [SIDE_W-1:0]       col_l;
  } op_t;

  logic [CFG_DATA_W-1:0] kernel_width_q, kernel_height_q;
  logic                  clamp_to_unit_q;
  logic                  cfg_we, kw_we, kh_we, cl_we;
  logic [SIDE_W-1:0]     w_eff, h_eff;
  logic                  f_valid, f_ready, b_valid, b_ready;
  op_t                   f_op, b_op;
  logic [SUM_W-1:0]      sum;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    kw_we = 1'b0;
    kh_we = 1'b0;
    cl_we = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KERNEL_WIDTH:  kw_we = 1'b1;
        CFG_KERNEL_HEIGHT: kh_we = 1'b1;
        CFG_CLAMP_TO_UNIT: cl_we = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_width_q  <= CFG_DATA_W'(1);
      kernel_height_q <= CFG_DATA_W'(1);
      clamp_to_unit_q <= 1'b0;
    end else begin
      if (kw_we) begin
        kernel_width_q <= cfg_data_i;
      end
      if (kh_we) begin
        kernel_height_q <= cfg_data_i;
      end
      if (cl_we) begin
        clamp_to_unit_q <= cfg_data_i[0];
      end
    end
  end

  // Kernel sides as used: at least one, at most the table side.
  always_comb begin
    if (kernel_width_q == '0) begin
      w_eff = SIDE_W'(1);
    end else if (int'(kernel_width_q) > int'(MAX_SIDE)) begin
      w_eff = SIDE_W'(MAX_SIDE);
    end else begin
      w_eff = SIDE_W'(kernel_width_q);
    end
    if (kernel_height_q == '0) begin
      h_eff = SIDE_W'(1);
    end else if (int'(kernel_height_q) > int'(MAX_SIDE)) begin
      h_eff = SIDE_W'(MAX_SIDE);
    end else begin
      h_eff = SIDE_W'(kernel_height_q);
    end
  end

  sars_front #(
    .MAX_SIDE(MAX_SIDE),
    .op_t    (op_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .entry_value_i(entry_value_i),
    .corner_x_i   (corner_x_i),
    .corner_y_i   (corner_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .w_i          (w_eff),
    .h_i          (h_eff),
    .restart_i    (kw_we || kh_we),
    .op_valid_o   (f_valid),
    .op_ready_i   (f_ready),
    .op_o         (f_op)
  );

  sars_fifo #(
    .DEPTH(2),
    .T    (op_t)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(f_valid),
    .ready_o(f_ready),
    .data_i (f_op),
    .valid_o(b_valid),
    .ready_i(b_ready),
    .data_o (b_op)
  );

  sars_back #(
    .MAX_SIDE(MAX_SIDE),
    .op_t    (op_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (b_valid),
    .op_ready_o  (b_ready),
    .op_i        (b_op),
    .clamp_i     (clamp_to_unit_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .region_sum_o(sum)
  );

  assign region_sum_o = signed'(sum);

endmodule

>>> rtl/sars_ram.sv
`timescale 1ns / 1ps

module sars_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sars_fifo.sv
`timescale 1ns / 1ps

module sars_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = valid_i && ready_o;
  assign do_pop  = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/sars_front.sv
`timescale 1ns / 1ps

module sars_front
  import sars_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64,
  parameter type         op_t     = logic
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      kind_i,
  input  logic signed [VAL_W-1:0]   entry_value_i,
  input  logic signed [COORD_W-1:0] corner_x_i,
  input  logic signed [COORD_W-1:0] corner_y_i,
  input  logic [LEN_W-1:0]          rect_width_i,
  input  logic [LEN_W-1:0]          rect_height_i,
  input  logic [$clog2(MAX_SIDE + 1)-1:0] w_i,
  input  logic [$clog2(MAX_SIDE + 1)-1:0] h_i,
  input  logic                      restart_i,
  output logic                      op_valid_o,
  input  logic                      op_ready_i,
  output op_t                       op_o
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW     = (SIDE_W + 1 > COORD_W + 2) ? SIDE_W + 1 : COORD_W + 2;
  localparam int unsigned PW     = 2 * SIDE_W;

  // Classified item, before the row offsets are multiplied out.
  typedef struct packed {
    kind_e                    kind;
    logic signed [VAL_W-1:0]  value;
    logic [AW-1:0]            pos;
    logic [AW-1:0]            above;
    logic                     col0;
    logic                     row_nz;
    logic                     nonempty;
    logic                     xs_nz;
    logic                     ys_nz;
    logic [SIDE_W-1:0]        xs_m1;
    logic [SIDE_W-1:0]        xe_m1;
    logic [SIDE_W-1:0]        ys_m1;
    logic [SIDE_W-1:0]        ye_m1;
  } stage_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic signed [CW-1:0] v,
                                                   input logic [SIDE_W-1:0]    lim);
    logic signed [CW-1:0] lim_s;
    lim_s = signed'(CW'(lim));
    if (v < 0) begin
      clamp_side = '0;
    end else if (v > lim_s) begin
      clamp_side = lim;
    end else begin
      clamp_side = v[SIDE_W-1:0];
    end
  endfunction

  stage_t               s1_q, s1_d;
  logic                 s1_valid_q, s1_valid_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [SIDE_W-1:0]    col_q, col_d;
  logic [SIDE_W-1:0]    row_q, row_d;
  logic                 accept, drain, is_load, last_col, last_row;
  logic signed [CW-1:0] x_s, y_s, xe_s, ye_s;
  logic [SIDE_W-1:0]    xs, xe, ys, ye;
  logic [PW-1:0]        prod_bot, prod_top;

  assign full_o   = s1_valid_q && !op_ready_i;
  assign accept   = push_i && !full_o;
  assign drain    = s1_valid_q && op_ready_i;
  assign is_load  = (kind_e'(kind_i) == KIND_LOAD);
  assign last_col = (col_q == w_i - 1'b1);
  assign last_row = (row_q == h_i - 1'b1);

  // Rectangle edges, clamped to the kernel.
  assign x_s  = CW'(corner_x_i);
  assign y_s  = CW'(corner_y_i);
  assign xe_s = x_s + signed'(CW'(rect_width_i));
  assign ye_s = y_s + signed'(CW'(rect_height_i));
  assign xs   = clamp_side(x_s, w_i);
  assign xe   = clamp_side(xe_s, w_i);
  assign ys   = clamp_side(y_s, h_i);
  assign ye   = clamp_side(ye_s, h_i);

  always_comb begin
    s1_d.kind     = kind_e'(kind_i);
    s1_d.value    = entry_value_i;
    s1_d.pos      = pos_q;
    s1_d.above    = pos_q - AW'(w_i);
    s1_d.col0     = (col_q == '0);
    s1_d.row_nz   = (row_q != '0);
    s1_d.nonempty = (xe > xs) && (ye > ys);
    s1_d.xs_nz    = (xs != '0);
    s1_d.ys_nz    = (ys != '0);
    s1_d.xs_m1    = xs - 1'b1;
    s1_d.xe_m1    = xe - 1'b1;
    s1_d.ys_m1    = ys - 1'b1;
    s1_d.ye_m1    = ye - 1'b1;
  end

  // Load position walks the kernel in row-major order.
  always_comb begin
    pos_d = pos_q;
    col_d = col_q;
    row_d = row_q;
    priority if (restart_i) begin
      pos_d = '0;
      col_d = '0;
      row_d = '0;
    end else if (accept && is_load) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d = '0;
          pos_d = '0;
        end else begin
          row_d = row_q + 1'b1;
          pos_d = pos_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
        pos_d = pos_q + 1'b1;
      end
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (drain) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pos_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      pos_q      <= pos_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // Row offsets of the bottom and top table rows; the queue registers them.
  assign prod_bot = PW'(s1_q.ye_m1) * PW'(w_i);
  assign prod_top = PW'(s1_q.ys_m1) * PW'(w_i);

  assign op_valid_o = s1_valid_q;

  always_comb begin
    op_o.kind     = s1_q.kind;
    op_o.value    = s1_q.value;
    op_o.pos      = s1_q.pos;
    op_o.above    = s1_q.above;
    op_o.col0     = s1_q.col0;
    op_o.row_nz   = s1_q.row_nz;
    op_o.nonempty = s1_q.nonempty;
    op_o.xs_nz    = s1_q.xs_nz;
    op_o.ys_nz    = s1_q.ys_nz;
    op_o.off_bot  = prod_bot[AW-1:0];
    op_o.off_top  = prod_top[AW-1:0];
    op_o.col_r    = s1_q.xe_m1;
    op_o.col_l    = s1_q.xs_m1;
  end

`ifndef SYNTHESIS
  // The load cursor always lies inside the configured kernel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < w_i) && (row_q < h_i))
    else $error("load cursor outside kernel");

  // Loading the last entry of the kernel wraps the position to the top left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load && last_col && last_row && !restart_i) |=>
      (pos_q == '0) && (col_q == '0) && (row_q == '0))
    else $error("load position did not wrap after the last entry");
`endif

endmodule

>>> rtl/sars_back.sv
`timescale 1ns / 1ps

module sars_back
  import sars_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 64,
  parameter type         op_t     = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  output logic             op_ready_o,
  input  op_t              op_i,
  input  logic             clamp_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [SUM_W-1:0] region_sum_o
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LD_WR = 6'b000010,
    ST_RD_L  = 6'b000100,
    ST_RD_T  = 6'b001000,
    ST_RD_C  = 6'b010000,
    ST_END   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  op_t              op_q, op_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0] rs_q, rs_d;
  logic [SUM_W-1:0] res_q, res_d;
  logic             res_valid_q, res_valid_d;
  logic             res_load;
  logic             ram_en, ram_we;
  logic [AW-1:0]    ram_addr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;
  logic [SUM_W-1:0] head_val, sum;

  assign head_val = SUM_W'(op_i.value);

  sars_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Final corner term and the optional clamp to the unit range.
  always_comb begin
    sum = acc_q + ((op_q.nonempty && op_q.xs_nz && op_q.ys_nz) ? ram_rdata : '0);
    res_d = sum;
    if (clamp_i) begin
      if (sum[SUM_W-1]) begin
        res_d = '0;
      end else if (sum > UNIT_Q16) begin
        res_d = UNIT_Q16;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    acc_d      = acc_q;
    rs_d       = rs_q;
    op_ready_o = 1'b0;
    res_load   = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = op_q.pos;
    ram_wdata  = rs_q + (op_q.row_nz ? ram_rdata : '0);
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_ready_o = 1'b1;
          op_d       = op_i;
          ram_en     = 1'b1;
          if (op_i.kind == KIND_LOAD) begin
            ram_addr = op_i.above;
            rs_d     = op_i.col0 ? head_val : rs_q + head_val;
            state_d  = ST_LD_WR;
          end else begin
            ram_addr = op_i.off_bot + AW'(op_i.col_r);
            acc_d    = '0;
            state_d  = ST_RD_L;
          end
        end
      end
      ST_LD_WR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = op_q.pos;
        state_d  = ST_IDLE;
      end
      ST_RD_L: begin
        ram_en   = 1'b1;
        ram_addr = op_q.off_bot + AW'(op_q.col_l);
        acc_d    = acc_q + (op_q.nonempty ? ram_rdata : '0);
        state_d  = ST_RD_T;
      end
      ST_RD_T: begin
        ram_en   = 1'b1;
        ram_addr = op_q.off_top + AW'(op_q.col_r);
        acc_d    = acc_q - ((op_q.nonempty && op_q.xs_nz) ? ram_rdata : '0);
        state_d  = ST_RD_C;
      end
      ST_RD_C: begin
        ram_en   = 1'b1;
        ram_addr = op_q.off_top + AW'(op_q.col_l);
        acc_d    = acc_q - ((op_q.nonempty && op_q.ys_nz) ? ram_rdata : '0);
        state_d  = ST_END;
      end
      ST_END: begin
        if (!res_valid_q || pop_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      rs_q        <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      rs_q        <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign empty_o      = !res_valid_q;
  assign region_sum_o = res_q;

`ifndef SYNTHESIS
  // A load taken from the queue is written back on the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && op_valid_i && op_i.kind == KIND_LOAD) |=>
      (state_q == ST_LD_WR) && ram_we)
    else $error("load did not proceed to its table write");

  // Every table write follows the read of the entry above it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(state_q == ST_IDLE && ram_en))
    else $error("table write without preceding read");

  // In clamp mode a delivered sum lies between zero and one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && clamp_i) |-> (!res_d[SUM_W-1] && (res_d <= UNIT_Q16)))
    else $error("clamped sum out of range");
`endif

endmodule
